FILE: design/ipvfh_pkg.sv
package ipvfh_pkg;

    localparam int unsigned CfgIndexWidth = 1;

    // Configuration register indexes
    localparam logic [CfgIndexWidth-1:0] REG_SOURCE_ADDR  = 1'd0;
    localparam logic [CfgIndexWidth-1:0] REG_MAX_DATA_LEN = 1'd1;

    localparam logic [10:0] MAX_DATA_LEN_RESET = 11'd1466;
    localparam logic [10:0] MAX_DATA_LEN_MIN   = 11'd1024;
    localparam logic [10:0] MAX_DATA_LEN_MAX   = 11'd1480;
    localparam logic [10:0] HDR_BYTES          = 11'd20;
    localparam logic [15:0] IDENT_LAST         = 16'hfffe;
    // Version 4 / IHL 5 and TTL 64 fixed header bytes
    localparam logic [7:0]  VER_IHL_BYTE       = 8'h45;
    localparam logic [7:0]  TTL_BYTE           = 8'h40;

    typedef struct packed {
        logic [31:0] dest_addr;
        logic [7:0]  protocol;
        logic [7:0]  type_of_service;
        logic [15:0] payload_len;
    } in_item_t;

    typedef struct packed {
        logic [10:0] total_len;
        logic [15:0] ident;
        logic        dont_fragment;
        logic        more_fragments;
        logic [12:0] offset_units;
        logic [15:0] header_checksum;
        logic [15:0] payload_offset;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic load;   // capture request, advance ident
        logic setup;  // form fixed part of the checksum
        logic step;   // emit one descriptor into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic fin;
    } dp_status_t;

endpackage

FILE: design/ipvfh_datapath.sv
module ipvfh_datapath import ipvfh_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_write,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [31:0]              cfg_data,
    input  in_item_t                 s_data,
    input  dp_cmd_t                  cmd,
    output dp_status_t               status,
    output out_item_t                m_data
);

    logic [31:0] source_addr_reg;
    logic [10:0] max_data_len_reg;
    logic [15:0] ident_reg;
    logic [15:0] ident_next;
    in_item_t    req_reg;
    logic [15:0] id_cur_reg;
    logic [10:0] maxlen_reg;
    logic [10:0] maxlen_next;
    logic [15:0] remaining_reg;
    logic [15:0] done_reg;
    logic [18:0] base_reg;
    logic [18:0] base_next;
    out_item_t   m_data_reg;
    out_item_t   m_data_next;

    logic [10:0] chunk;
    logic        fin;
    logic [10:0] plen;
    logic [10:0] tlen;
    logic        df;
    logic [15:0] flagoff;
    logic [19:0] sum;
    logic [16:0] fold1;
    logic [15:0] fold2;

    always_comb begin
        maxlen_next = max_data_len_reg;
        if (max_data_len_reg < MAX_DATA_LEN_MIN) begin
            maxlen_next = MAX_DATA_LEN_MIN;
        end else if (max_data_len_reg > MAX_DATA_LEN_MAX) begin
            maxlen_next = MAX_DATA_LEN_MAX;
        end
        ident_next = (ident_reg == IDENT_LAST) ? 16'd0 : ident_reg + 16'd1;
    end

    // fixed header words: tos, ident, ttl/proto, source and destination
    assign base_next = 19'({VER_IHL_BYTE, req_reg.type_of_service})
                     + 19'(id_cur_reg)
                     + 19'({TTL_BYTE, req_reg.protocol})
                     + 19'(source_addr_reg[31:16]) + 19'(source_addr_reg[15:0])
                     + 19'(req_reg.dest_addr[31:16]) + 19'(req_reg.dest_addr[15:0]);

    assign chunk   = {maxlen_reg[10:3], 3'b000};
    assign fin     = remaining_reg <= {5'd0, maxlen_reg};
    assign plen    = fin ? remaining_reg[10:0] : chunk;
    assign tlen    = plen + HDR_BYTES;
    assign df      = fin && (done_reg == 16'd0);
    assign flagoff = {1'b0, df, !fin, done_reg[15:3]};
    assign sum     = 20'(base_reg) + 20'(tlen) + 20'(flagoff);
    assign fold1   = 17'(sum[15:0]) + 17'(sum[19:16]);
    assign fold2   = fold1[15:0] + 16'(fold1[16]);

    always_comb begin
        m_data_next.total_len       = tlen;
        m_data_next.ident           = id_cur_reg;
        m_data_next.dont_fragment   = df;
        m_data_next.more_fragments  = !fin;
        m_data_next.offset_units    = done_reg[15:3];
        m_data_next.header_checksum = ~fold2;
        m_data_next.payload_offset  = done_reg;
        m_data_next.last            = fin;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_addr_reg  <= 32'd0;
            max_data_len_reg <= MAX_DATA_LEN_RESET;
            ident_reg        <= 16'd0;
        end else begin
            if (cfg_write) begin
                unique case (cfg_index)
                    REG_SOURCE_ADDR:  source_addr_reg  <= cfg_data;
                    REG_MAX_DATA_LEN: max_data_len_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
            if (cmd.load) begin
                ident_reg <= ident_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg       <= s_data;
            id_cur_reg    <= ident_reg;
            maxlen_reg    <= maxlen_next;
            remaining_reg <= s_data.payload_len;
            done_reg      <= 16'd0;
        end
        if (cmd.setup) begin
            base_reg <= base_next;
        end
        if (cmd.step) begin
            m_data_reg    <= m_data_next;
            remaining_reg <= fin ? 16'd0 : remaining_reg - 16'(chunk);
            done_reg      <= done_reg + 16'(chunk);
        end
    end

    assign status.len_zero = remaining_reg == 16'd0;
    assign status.fin      = fin;
    assign m_data          = m_data_reg;

endmodule

FILE: design/ipvfh_ctrl.sv
module ipvfh_ctrl import ipvfh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       m_valid_reg;
    logic       m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                cmd.setup  = 1'b1;
                // empty request: drop, ident has already advanced
                state_next = status.len_zero ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    cmd.step     = 1'b1;
                    m_valid_next = 1'b1;
                    if (status.fin) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;
    assign m_valid = m_valid_reg;

endmodule

FILE: design/ipv4_fragment_header_gen_top.sv
// IPv4 fragment header generator.
// Input channel (s_valid/s_ready/s_data): one send request per transaction,
// carrying destination, protocol, TOS and payload length.
// Result channel (m_valid/m_ready/m_data): one header descriptor per fragment,
// in offset order; the final descriptor of a request has last set.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is
// the source address, index 1 the maximum payload per packet (used clamped
// to 1024..1480); always ready, write only while no request is in flight.
// Sequence: a request is taken in the idle state, the fixed header words are
// summed in the setup state, then descriptors leave at one per cycle while
// the receiver accepts them; each is valid once registered in the output
// register. A zero-length request passes through the idle and setup states,
// advances the ident and gives no descriptor.
// The sequencer handles one request at a time; the next request is taken as
// soon as the last descriptor sits in the output register.
// A stalled receiver holds the output register and freezes the sequencer in its emit state.
// Reset clears the ident counter, the source address and sets the maximum
// payload to 1466; no descriptor is pending after reset.
module ipv4_fragment_header_gen_top import ipvfh_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic [31:0]              cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  in_item_t                 s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output out_item_t                m_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // configuration writes complete at once
    assign cfg_ready = 1'b1;

    ipvfh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ipvfh_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule

FILE: bench/tb_ipv4_fragment_header_gen_top.sv
`timescale 1ns / 100ps

module tb_ipv4_fragment_header_gen_top;
    import ipvfh_pkg::*;

    // IPv4 flag bits as they sit in the flags/offset word
    localparam logic [15:0] FLAG_DF = 16'h4000;
    localparam logic [15:0] FLAG_MF = 16'h2000;
    localparam int unsigned FRAG_CAP = 64;
    // Cycles without any transaction before the run is declared hung
    localparam int unsigned STALL_LIMIT = 5000;
    // Cycles to let a request with no descriptor finish before touching registers
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned IDLE_PCT = 15;
    localparam int unsigned ITEMS_PER_SETTING = 22;
    localparam int unsigned SHOW_LIMIT = 10;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CfgIndexWidth-1:0] cfg_index = '0;
    logic [31:0]              cfg_data = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_item_t                m_data;

    // Shadow copy of the block's registers and ident counter
    logic [31:0] src_reg = '0;
    logic [10:0] mdl_reg = MAX_DATA_LEN_RESET;
    logic [15:0] ident_ctr = '0;

    in_item_t    req_queue[$];      // send requests waiting for the driver
    out_item_t   hdr_expect[$];     // descriptors predicted, not yet seen
    int unsigned req_pushed = 0;
    int unsigned req_taken = 0;
    int unsigned err_count = 0;
    int unsigned shown = 0;
    int unsigned quiet_cycles = 0;
    bit          s_fire = 1'b0;

    // Receiver back-pressure control
    bit          hold_arm = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;
    bit          calm = 1'b0;       // suppress random idling on both sides

    ipv4_fragment_header_gen_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Clamp the programmed maximum payload to the range the block uses
    function automatic int unsigned used_max();
        if (mdl_reg < MAX_DATA_LEN_MIN) return 32'(MAX_DATA_LEN_MIN);
        if (mdl_reg > MAX_DATA_LEN_MAX) return 32'(MAX_DATA_LEN_MAX);
        return 32'(mdl_reg);
    endfunction

    // Ones-complement sum over the nine big-endian header words other than the checksum, inverted
    function automatic logic [15:0] header_sum(input logic [7:0] tos, input logic [15:0] tlen,
                                               input logic [15:0] id, input logic [15:0] flagoff,
                                               input logic [7:0] proto, input logic [31:0] src,
                                               input logic [31:0] dst);
        int unsigned acc;
        acc = 32'({VER_IHL_BYTE, tos}) + 32'(tlen) + 32'(id) + 32'(flagoff)
            + 32'({TTL_BYTE, proto}) + 32'(src[31:16]) + 32'(src[15:0])
            + 32'(dst[31:16]) + 32'(dst[15:0]);
        while ((acc >> 16) != 0)
            acc = (acc & 32'hffff) + (acc >> 16);
        return ~acc[15:0];
    endfunction

    // Split one send request into fragment descriptors and queue them
    function automatic void predict_headers(input in_item_t req);
        int unsigned maxlen, chunk, remaining, done, plen, tlen, n;
        logic [15:0] id, flagoff;
        bit          fin;
        out_item_t   hdr;
        maxlen = used_max();
        chunk = (maxlen / 8) * 8;
        remaining = 32'(req.payload_len);
        done = 0;
        n = 0;
        id = ident_ctr;
        while (remaining != 0 && n < FRAG_CAP) begin
            if (remaining <= maxlen) begin
                plen = remaining;
                fin = 1'b1;
                // a packet that fits whole goes out with DF; a tail carries its offset
                flagoff = (done == 0) ? FLAG_DF : 16'((done >> 3) & 32'h1fff);
            end else begin
                plen = chunk;
                fin = 1'b0;
                flagoff = FLAG_MF | 16'((done >> 3) & 32'h1fff);
            end
            tlen = (plen + HDR_BYTES) & 32'h7ff;
            hdr.total_len       = tlen[10:0];
            hdr.ident           = id;
            hdr.dont_fragment   = flagoff[14];
            hdr.more_fragments  = flagoff[13];
            hdr.offset_units    = flagoff[12:0];
            hdr.header_checksum = header_sum(req.type_of_service, 16'(tlen), id, flagoff,
                                             req.protocol, src_reg, req.dest_addr);
            hdr.payload_offset  = done[15:0];
            hdr.last            = fin;
            hdr_expect.push_back(hdr);
            n++;
            remaining = fin ? 0 : remaining - chunk;
            done += chunk;
        end
        // ident wraps modulo 65535, so 0xfffe is followed by zero
        ident_ctr = (id == IDENT_LAST) ? 16'd0 : id + 16'd1;
    endfunction

    function automatic in_item_t mk_req(input logic [31:0] dst, input logic [7:0] proto,
                                        input logic [7:0] tos, input logic [15:0] len);
        in_item_t r;
        r.dest_addr = dst;
        r.protocol = proto;
        r.type_of_service = tos;
        r.payload_len = len;
        return r;
    endfunction

    // Random request; lengths cluster around the fragment boundaries
    function automatic in_item_t random_req();
        in_item_t    r;
        int unsigned lim, chk, pick, len;
        lim = used_max();
        chk = (lim / 8) * 8;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            len = 0;
        else if (pick < 40)
            len = $urandom_range(1, lim);
        else if (pick < 60) begin
            if ($urandom_range(0, 1) == 1)
                len = lim - 4 + $urandom_range(0, 8);
            else
                len = $urandom_range(1, 8) * chk - 4 + $urandom_range(0, 8);
        end else if (pick < 90)
            len = $urandom_range(lim + 1, 12000);
        else
            len = $urandom_range(12000, 65535);
        r = mk_req($urandom, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 16'(len));
        return r;
    endfunction

    task automatic queue_req(input in_item_t r);
        req_queue.push_back(r);
        req_pushed++;
    endtask

    // Write one register through the configuration channel and mirror it
    task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_SOURCE_ADDR)
            src_reg = val;
        else if (idx == REG_MAX_DATA_LEN)
            mdl_reg = val[10:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every request is taken and every descriptor seen, then drain
    task automatic settle();
        do @(negedge aclk); while (req_taken != req_pushed || hdr_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Request driver: advance to the next queued request once the current
    // transaction completes, idling at random between requests.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (req_queue.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_data <= req_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Descriptor receiver: random stalls, plus one long hold-off that lets
    // the block fill up and push back on the request side.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_arm && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on each request transaction, check each descriptor
    // transaction against the oldest prediction, and watch for a hang.
    always @(posedge aclk) begin
        out_item_t want;
        bit        m_fire;
        if (!aresetn) begin
            s_fire = 1'b0;
            quiet_cycles = 0;
        end else begin
            s_fire = s_valid && s_ready;
            m_fire = m_valid && m_ready;
            if (s_fire) begin
                predict_headers(s_data);
                req_taken++;
            end
            if (m_fire) begin
                if (hdr_expect.size() == 0) begin
                    err_count++;
                    if (shown < SHOW_LIMIT) begin
                        shown++;
                        $display("unexpected descriptor with nothing pending: %h", m_data);
                    end
                end else begin
                    want = hdr_expect.pop_front();
                    if (m_data.total_len !== want.total_len || m_data.ident !== want.ident ||
                        m_data.dont_fragment !== want.dont_fragment ||
                        m_data.more_fragments !== want.more_fragments ||
                        m_data.offset_units !== want.offset_units ||
                        m_data.header_checksum !== want.header_checksum ||
                        m_data.payload_offset !== want.payload_offset ||
                        m_data.last !== want.last) begin
                        err_count++;
                        if (shown < SHOW_LIMIT) begin
                            shown++;
                            $display("descriptor mismatch");
                            $display("  expected len=%0d id=%h df=%b mf=%b off=%0d csum=%h poff=%0d last=%b",
                                     want.total_len, want.ident, want.dont_fragment,
                                     want.more_fragments, want.offset_units,
                                     want.header_checksum, want.payload_offset, want.last);
                            $display("  actual   len=%0d id=%h df=%b mf=%b off=%0d csum=%h poff=%0d last=%b",
                                     m_data.total_len, m_data.ident, m_data.dont_fragment,
                                     m_data.more_fragments, m_data.offset_units,
                                     m_data.header_checksum, m_data.payload_offset, m_data.last);
                        end
                    end
                end
            end
            if (s_fire || m_fire || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ipv4_fragment_header_gen_top test failed");
                $finish;
            end
        end
    end

    // Stimulus sequence: directed requests, then register sweeps with random
    // traffic.
    initial begin
        int unsigned ph, k;
        logic [31:0] src_pick, mdl_word;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset values: max payload 1466, fragment size 1464
        queue_req(mk_req(32'h0000_0000, 8'h00, 8'h00, 16'd1));
        queue_req(mk_req(32'hffff_ffff, 8'hff, 8'hff, 16'd1466));
        queue_req(mk_req(32'h0000_0001, 8'h06, 8'h10, 16'd1467));
        queue_req(mk_req(32'h8000_0000, 8'h11, 8'h00, 16'd0));
        queue_req(mk_req(32'hc0a8_0101, 8'h01, 8'hb8, 16'd0));
        queue_req(mk_req(32'hffff_ffff, 8'hff, 8'hff, 16'd65535));
        queue_req(mk_req(32'h0a00_0002, 8'h11, 8'h00, 16'd1464));
        queue_req(mk_req(32'h5555_aaaa, 8'h2f, 8'h55, 16'd2928));
        queue_req(mk_req(32'haaaa_5555, 8'h32, 8'haa, 16'd2930));
        queue_req(mk_req(32'h1234_5678, 8'h11, 8'h00, 16'd2931));
        queue_req(mk_req(32'h0000_0000, 8'h00, 8'hff, 16'd8));
        queue_req(mk_req(32'hffff_ffff, 8'hff, 8'h00, 16'd7));
        queue_req(mk_req(32'ha5a5_a5a5, 8'h11, 8'h10, 16'd1500));
        queue_req(mk_req(32'h5a5a_5a5a, 8'h06, 8'h04, 16'h8000));
        queue_req(mk_req(32'h0f0f_f0f0, 8'h84, 8'h20, 16'h7fff));
        queue_req(mk_req(32'hfffe_0001, 8'h80, 8'h01, 16'd1465));
        queue_req(mk_req(32'h0001_fffe, 8'h7f, 8'hfe, 16'd1472));
        queue_req(mk_req(32'hdead_beef, 8'h40, 8'h80, 16'd4392));

        // Smallest fragment size
        settle();
        write_reg(REG_SOURCE_ADDR, $urandom);
        write_reg(REG_MAX_DATA_LEN, 32'd1024);
        queue_req(mk_req(32'hc633_6401, 8'h11, 8'h00, 16'd1024));
        queue_req(mk_req(32'hc633_6402, 8'h06, 8'h08, 16'd1025));
        queue_req(mk_req(32'hc633_6403, 8'hff, 8'hff, 16'd65535));

        // Largest fragment size
        settle();
        write_reg(REG_SOURCE_ADDR, 32'hffff_ffff);
        write_reg(REG_MAX_DATA_LEN, 32'd1480);
        queue_req(mk_req(32'h0000_0000, 8'h11, 8'h00, 16'd1480));
        queue_req(mk_req(32'h0000_0000, 8'h06, 8'h00, 16'd1481));
        queue_req(mk_req(32'hffff_ffff, 8'hff, 8'hff, 16'd65535));

        // Register sweeps, including values outside the clamp range
        for (ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0: begin
                    src_pick = 32'h0000_0000;
                    mdl_word = {21'($urandom_range(0, 2097151)), 11'd0};
                end
                1: begin src_pick = $urandom; mdl_word = {21'h1fffff, 11'h7ff}; end
                2: begin src_pick = 32'hffff_ffff; mdl_word = 32'd1023; end
                3: begin src_pick = $urandom; mdl_word = 32'd1481; end
                4: begin src_pick = $urandom; mdl_word = 32'd1024; end
                5: begin src_pick = $urandom; mdl_word = 32'd1480; end
                6: begin src_pick = $urandom; mdl_word = $urandom_range(1024, 1480); end
                default: begin src_pick = $urandom; mdl_word = $urandom; end
            endcase
            write_reg(REG_SOURCE_ADDR, src_pick);
            write_reg(REG_MAX_DATA_LEN, mdl_word);
            hold_arm = (ph >= 1);
            calm = (ph == 4);
            for (k = 0; k < ITEMS_PER_SETTING; k++)
                queue_req(random_req());
        end

        settle();
        if (err_count == 0 && hdr_expect.size() == 0)
            $display("ipv4_fragment_header_gen_top test passed");
        else
            $display("ipv4_fragment_header_gen_top test failed");
        $finish;
    end

endmodule

FILE: files.f
design/ipvfh_pkg.sv
design/ipvfh_datapath.sv
design/ipvfh_ctrl.sv
design/ipv4_fragment_header_gen_top.sv
bench/tb_ipv4_fragment_header_gen_top.sv
